// ----- design/sha_pkg.sv -----
package sha_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage

// ----- design/sha_queue.sv -----
// Small FIFO between the byte front end and the compression back end.
module sha_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sha_pkg::in_item_t push_data,
  output logic             full,
  input  logic             pop,
  output sha_pkg::in_item_t pop_data,
  output logic             empty
);
  import sha_pkg::*;

  in_item_t             mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueuePtrW:0]   count;

  assign full     = (count == (QueuePtrW+1)'(QueueDepth));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

// ----- design/sha_core.sv -----
// Back end: block buffer, padding, one round per cycle, digest read-out.
module sha_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  sha_pkg::in_item_t  q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output sha_pkg::out_item_t out_data
);
  import sha_pkg::*;

  localparam logic [2:0] ST_TAKE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_ADD   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]  state;
  logic [31:0] blk [16];    // block buffer, big-endian bytes within each word
  logic [5:0]  fill;
  logic [63:0] total;
  logic [31:0] h [8];
  logic [31:0] r [8];
  logic [31:0] w [16];
  logic [5:0]  rnd;
  logic [5:0]  pad_idx;
  logic        final_blk;   // block being compressed ends the message
  logic        pad_second;  // a length-only block follows
  logic [2:0]  emit_idx;
  logic [63:0] bits;

  logic [31:0] w_cur, w_new, s0, s1, t1, t2, e, a;

  assign bits = {total[60:0], 3'b000};

  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    w_cur = w[0];
    e = r[4];
    a = r[0];
    t1 = r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
         ((e & r[5]) ^ (~e & r[6])) + ROUND_K[rnd] + w_cur;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
         ((a & r[1]) ^ (a & r[2]) ^ (r[1] & r[2]));
  end

  assign q_pop     = (state == ST_TAKE) && !q_empty;
  assign out_valid = (state == ST_EMIT);
  assign out_data  = '{digest_word: h[emit_idx], word_index: emit_idx,
                       last_word: (emit_idx == 3'd7)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_TAKE;
      fill  <= '0;
      total <= '0;
      for (int i = 0; i < 8; i++) h[i] <= INIT_H[i];
      rnd <= '0; pad_idx <= '0; final_blk <= 1'b0; pad_second <= 1'b0;
      emit_idx <= '0;
    end else begin
      unique case (state)
        ST_TAKE: begin
          if (!q_empty) begin
            blk[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <=
              (q_data.action == ACT_ABSORB) ? q_data.data_byte : PAD_MARK;
            if (q_data.action == ACT_ABSORB) begin
              fill  <= fill + 1'b1;
              total <= total + 64'd1;
              final_blk <= 1'b0;
              if (fill == 6'd63) state <= ST_LOAD;
            end else begin
              pad_idx    <= fill + 1'b1;
              pad_second <= (fill >= 6'd56);
              final_blk  <= (fill < 6'd56);
              state      <= (fill == 6'd63) ? ST_LOAD : ST_PAD;
            end
          end
        end
        ST_PAD: begin
          // zero fill, then length bytes in the tail when this is the last block
          if (!pad_second && pad_idx >= LEN_OFFSET)
            blk[pad_idx[5:2]][{~pad_idx[1:0], 3'b000} +: 8] <=
              bits[8*(6'd63 - pad_idx) +: 8];
          else
            blk[pad_idx[5:2]][{~pad_idx[1:0], 3'b000} +: 8] <= 8'h00;
          pad_idx <= pad_idx + 1'b1;
          if (pad_idx == 6'd63) state <= ST_LOAD;
        end
        ST_LOAD: begin
          for (int i = 0; i < 16; i++) w[i] <= blk[i];
          for (int i = 0; i < 8; i++) r[i] <= h[i];
          rnd   <= '0;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          r[7] <= r[6]; r[6] <= r[5]; r[5] <= e; r[4] <= r[3] + t1;
          r[3] <= r[2]; r[2] <= r[1]; r[1] <= a; r[0] <= t1 + t2;
          rnd <= rnd + 1'b1;
          if (rnd == 6'd63) state <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + r[i];
          fill <= '0;
          if (pad_second) begin
            pad_second <= 1'b0;
            final_blk  <= 1'b1;
            pad_idx    <= '0;
            state      <= ST_PAD;
          end else if (final_blk) begin
            emit_idx <= '0;
            state    <= ST_EMIT;
          end else begin
            state <= ST_TAKE;
          end
        end
        ST_EMIT: begin
          if (!out_stall) begin
            emit_idx <= emit_idx + 1'b1;
            if (emit_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) h[i] <= INIT_H[i];
              total     <= '0;
              final_blk <= 1'b0;
              state     <= ST_TAKE;
            end
          end
        end
        default: state <= ST_TAKE;
      endcase
    end
  end
endmodule

// ----- design/sha256_stream_hasher_unit.sv -----
// Streaming SHA-256. Each input transfer either absorbs one byte (action 0)
// or finishes the message (action 1); a finish yields eight output
// transfers, digest words 0..7, last_word set on word 7, after which the
// hash restarts from the initial values. Bytes enter a four-entry queue, so
// the source is only stalled when the queue is full. The back end takes one
// queued item per cycle while it collects a block; each full 64-byte block
// is then compressed (load, one round per cycle, final add). A finish costs
// the remaining zero fill (one byte per cycle) plus one or two compressions,
// then the digest read-out, which holds while the receiver stalls.
module sha256_stream_hasher_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sha_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sha_pkg::out_item_t out_data
);
  import sha_pkg::*;

  logic     q_full, q_empty, q_pop;
  in_item_t q_data;

  // front end: every accepted transfer lands in the queue
  assign in_stall = q_full;

  sha_queue u_queue (
    .clk(clk), .rst(rst),
    .push(in_valid), .push_data(in_data), .full(q_full),
    .pop(q_pop), .pop_data(q_data), .empty(q_empty)
  );

  sha_core u_core (
    .clk(clk), .rst(rst),
    .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );
endmodule

// ----- tb/sha256_stream_hasher_unit_test.sv -----
module sha256_stream_hasher_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sha_pkg::*;

  // Digest scoreboard: keeps its own SHA-256 state, turns every accepted
  // transfer into expected digest words and checks the output side in order.
  class digest_scoreboard;
    logic [31:0] hash_state [8];
    logic [7:0]  block_buf [64];
    int unsigned fill;
    logic [63:0] msg_bytes;
    out_item_t   pending [$];
    int          mismatches;
    int          words_checked;
    int          messages_done;

    function void clear_hash();
      for (int i = 0; i < 8; i++) hash_state[i] = INIT_H[i];
      fill = 0;
      msg_bytes = '0;
    endfunction

    function new();
      mismatches = 0;
      words_checked = 0;
      messages_done = 0;
      for (int i = 0; i < 64; i++) block_buf[i] = '0;
      clear_hash();
    endfunction

    function logic [31:0] ror(logic [31:0] v, int n);
      return (v >> n) | (v << (32 - n));
    endfunction

    function void crunch_block();
      logic [31:0] w [64];
      logic [31:0] r [8];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
        w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
      for (int i = 16; i < 64; i++) begin
        s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) r[i] = hash_state[i];
      for (int i = 0; i < 64; i++) begin
        t1 = r[7] + (ror(r[4], 6) ^ ror(r[4], 11) ^ ror(r[4], 25))
             + ((r[4] & r[5]) ^ (~r[4] & r[6])) + ROUND_K[i] + w[i];
        t2 = (ror(r[0], 2) ^ ror(r[0], 13) ^ ror(r[0], 22))
             + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
        r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
        r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += r[i];
    endfunction

    function void note_input(in_item_t it);
      logic [63:0] bit_len;
      out_item_t   o;
      if (it.action == ACT_ABSORB) begin
        block_buf[fill] = it.data_byte;
        fill = (fill + 1) % 64;
        msg_bytes += 64'd1;
        if (fill == 0) crunch_block();
        return;
      end
      bit_len = msg_bytes << 3;
      block_buf[fill] = PAD_MARK;
      fill++;
      if (fill > LEN_OFFSET) begin
        for (int i = fill; i < 64; i++) block_buf[i] = '0;
        crunch_block();
        fill = 0;
      end
      for (int i = fill; i < LEN_OFFSET; i++) block_buf[i] = '0;
      for (int i = 0; i < 8; i++) block_buf[63-i] = bit_len[8*i +: 8];
      crunch_block();
      for (int i = 0; i < 8; i++) begin
        o.digest_word = hash_state[i];
        o.word_index  = 3'(i);
        o.last_word   = (i == 7);
        pending.push_back(o);
      end
      messages_done++;
      clear_hash();
    endfunction

    function void check_output(out_item_t got);
      out_item_t exp_w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transfer %h", got);
        return;
      end
      exp_w = pending.pop_front();
      words_checked++;
      if (got.digest_word !== exp_w.digest_word || got.word_index !== exp_w.word_index ||
          got.last_word !== exp_w.last_word) begin
        mismatches++;
        if (mismatches <= 10)
          $display("digest mismatch: exp word %h idx %0d last %b, got word %h idx %0d last %b",
                   exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                   got.digest_word, got.word_index, got.last_word);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  digest_scoreboard sb = new();
  in_item_t  send_q [$];      // transfers still to be offered
  bit        stim_done = 1'b0;
  bit        hold_rx = 1'b0;  // asks the receiver for a long hold-off
  int        idle_cycles = 0;
  int        sent_cnt = 0;

  localparam int IdleLimit = 20000;

  always #5 clk = ~clk;

  sha256_stream_hasher_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Sampling at the rising edge; the scoreboard sees both sides here.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_output(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transfer for %0d cycles", IdleLimit);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Receiver: own stall pattern, stretches without stalls, one long hold-off.
  initial begin : rx_side
    int mode;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_rx) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_rx = 1'b0;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(4, 40)) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // Offers one transfer; valid stays high across back-to-back transfers.
  task automatic send_item(in_item_t it, bit keep);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_cnt++;
    @(negedge clk);
    if (!keep) in_valid <= 1'b0;
  endtask

  task automatic push_msg(int unsigned len, bit fixed_val, logic [7:0] val);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      it.action = ACT_ABSORB;
      it.data_byte = fixed_val ? val : 8'($urandom_range(0, 255));
      send_q.push_back(it);
    end
    it.action = ACT_FINISH;
    it.data_byte = 8'($urandom);
    send_q.push_back(it);
  endtask

  // Sender: bursts of random length, mostly separated by random gaps.
  task automatic drain_queue();
    int burst;
    while (send_q.size() > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && send_q.size() > 0) begin
        send_item(send_q.pop_front(), burst > 1 && send_q.size() > 1);
        burst--;
      end
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic wait_results();
    while (sb.pending.size() > 0) @(negedge clk);
  endtask

  initial begin : main
    int unsigned lens [$];
    in_item_t odd;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty message, "abc", finish carrying data, extreme byte values
    // and a back-to-back pair of finishes.
    push_msg(0, 1'b0, 8'h00);
    send_q.push_back('{action: ACT_ABSORB, data_byte: 8'h61});
    send_q.push_back('{action: ACT_ABSORB, data_byte: 8'h62});
    send_q.push_back('{action: ACT_ABSORB, data_byte: 8'h63});
    send_q.push_back('{action: ACT_FINISH, data_byte: 8'hff});
    push_msg(1, 1'b1, 8'hff);
    push_msg(2, 1'b1, 8'h00);
    odd = '{action: ACT_FINISH, data_byte: 8'h00};
    send_q.push_back(odd);
    drain_queue();
    wait_results();

    // Padding borders: 56 and 63 need two blocks, 64 fills a whole one.
    lens = '{56, 63, 64};
    foreach (lens[i]) push_msg(lens[i], 1'b0, 8'h00);
    drain_queue();
    // Pause until every digest has come back before the stress part.
    wait_results();

    // Long receiver hold-off while the sender keeps offering: fills the queue.
    hold_rx = 1'b1;
    push_msg(2, 1'b0, 8'h00);
    push_msg(6, 1'b0, 8'h00);
    drain_queue();

    // Random short messages up to the item budget.
    while (sent_cnt < 212) begin
      push_msg($urandom_range(0, 8), 1'b0, 8'h00);
      drain_queue();
    end
    stim_done = 1'b1;

    wait_results();
    repeat (400) @(negedge clk);
    $display("covered %0d transfers, %0d messages, %0d digest words checked",
             sent_cnt, sb.messages_done, sb.words_checked);
    $display("including empty, block-border and multi-block messages under back-pressure");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d words outstanding", sb.mismatches, sb.pending.size());
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
